// ===== rtl/kts_pkg.sv =====
// Package for the Kalman trajectory smoother: widths, constants, register indexes,
// state encodings and the control structs passed between the core and its lanes.
// No dependencies.
`timescale 1ns / 1ps

package kts_pkg;

    localparam int ACC_WIDTH_DEF = 48;
    localparam int DATA_W        = 32;
    localparam int NUM_AXES      = 3;
    localparam int FRAC_BITS     = 28;
    localparam int GAIN_W        = FRAC_BITS + 1;
    localparam int DEN_W         = DATA_W + 1;
    localparam int REM_W         = DATA_W + 2;
    localparam int PROD_W        = GAIN_W + DATA_W;
    localparam int DIV_STEPS     = GAIN_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int CFG_INDEX_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_NOISE = 8'd1;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd53687;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd536870912;
    localparam logic [DATA_W-1:0] COV_ONE           = 32'd268435456;
    localparam logic [GAIN_W-1:0] GAIN_ONE          = 29'h1000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_MAG,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } kts_state_t;

    typedef enum logic [1:0] {
        GS_IDLE,
        GS_PREP,
        GS_DIV,
        GS_COV
    } kts_gain_state_t;

    typedef struct packed {
        logic load;
        logic first;
        logic mag;
        logic mul;
        logic upd;
    } kts_lane_ctrl_t;

    typedef struct packed {
        logic start;
        logic init;
    } kts_gain_ctrl_t;

endpackage

// ===== rtl/kts_gain.sv =====
// Shared gain unit: predicted covariance, a bit-serial restoring divider for the
// gain and the covariance update. Depends on kts_pkg.
`timescale 1ns / 1ps

module kts_gain (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  kts_pkg::kts_gain_ctrl_t      ctrl,
    input  logic [kts_pkg::DATA_W-1:0]   process_noise,
    input  logic [kts_pkg::DATA_W-1:0]   measure_noise,
    output logic [kts_pkg::GAIN_W-1:0]   gain,
    output logic                         done
);
    import kts_pkg::*;

    kts_gain_state_t         state_reg, state_next;
    logic [DATA_W-1:0]       cov_reg, cov_next;
    logic [DATA_W-1:0]       pp_reg, pp_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [GAIN_W-1:0]       quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W:0]         pp_sum;
    logic [DATA_W-1:0]       pp_sat;
    logic [DEN_W-1:0]        den_sum;
    logic                    rem_ge;
    logic [REM_W-1:0]        rem_diff;
    logic [PROD_W-1:0]       cov_prod;

    assign pp_sum   = {1'b0, cov_reg} + {1'b0, process_noise};
    assign pp_sat   = pp_sum[DATA_W] ? {DATA_W{1'b1}} : pp_sum[DATA_W-1:0];
    assign den_sum  = {1'b0, pp_reg} + {1'b0, measure_noise};
    assign rem_ge   = rem_reg >= {1'b0, den_reg};
    assign rem_diff = rem_ge ? rem_reg - {1'b0, den_reg} : rem_reg;
    assign cov_prod = (GAIN_ONE - quo_reg) * pp_reg;

    assign gain = quo_reg;
    assign done = (state_reg == GS_COV);

    always_comb begin
        state_next = state_reg;
        cov_next   = cov_reg;
        pp_next    = pp_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            GS_IDLE: begin
                if (ctrl.init) begin
                    cov_next = COV_ONE;
                end
                if (ctrl.start) begin
                    pp_next    = pp_sat;
                    rem_next   = REM_W'(pp_sat);
                    state_next = GS_PREP;
                end
            end
            GS_PREP: begin
                den_next = den_sum;
                quo_next = '0;
                cnt_next = DIV_CNT_W'(DIV_STEPS);
                if (den_sum == '0) begin
                    state_next = GS_COV;
                end else begin
                    state_next = GS_DIV;
                end
            end
            GS_DIV: begin
                quo_next = {quo_reg[GAIN_W-2:0], rem_ge};
                rem_next = {rem_diff[REM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    state_next = GS_COV;
                end
            end
            GS_COV: begin
                cov_next   = cov_prod[FRAC_BITS +: DATA_W];
                state_next = GS_IDLE;
            end
            default: begin
                state_next = GS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= GS_IDLE;
            cov_reg   <= COV_ONE;
        end else begin
            state_reg <= state_next;
            cov_reg   <= cov_next;
        end
    end

    always_ff @(posedge aclk) begin
        pp_reg  <= pp_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ===== rtl/kts_lane.sv =====
// One axis lane: trajectory accumulator, estimate update by the shared gain and
// the saturated corrected-motion result. Depends on kts_pkg.
`timescale 1ns / 1ps

module kts_lane #(
    parameter int ACC_WIDTH = kts_pkg::ACC_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  kts_pkg::kts_lane_ctrl_t            ctrl,
    input  logic signed [kts_pkg::DATA_W-1:0]  motion,
    input  logic [kts_pkg::GAIN_W-1:0]         gain,
    output logic signed [kts_pkg::DATA_W-1:0]  fixed_val
);
    import kts_pkg::*;

    localparam logic signed [ACC_WIDTH+1:0] OUT_MAX = (ACC_WIDTH+2)'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_WIDTH+1:0] OUT_MIN = (ACC_WIDTH+2)'(32'sh8000_0000);

    logic signed [ACC_WIDTH-1:0] traj_reg;
    logic signed [ACC_WIDTH-1:0] est_reg;
    logic signed [DATA_W-1:0]    motion_reg;
    logic [ACC_WIDTH-1:0]        mag_reg;
    logic                        up_reg;
    logic [PROD_W-1:0]           prod_lo_reg;
    logic [PROD_W-1:0]           prod_hi_reg;

    logic signed [ACC_WIDTH:0]   traj_sum;
    logic [ACC_WIDTH-1:0]        traj_clamped;
    logic signed [ACC_WIDTH:0]   diff;
    logic signed [ACC_WIDTH:0]   neg_diff;
    logic [63:0]                 mag_ext;
    logic [63:0]                 step_full;
    logic [ACC_WIDTH-1:0]        step;
    logic [ACC_WIDTH-1:0]        est_upd;
    logic signed [ACC_WIDTH+1:0] out_sum;

    assign traj_sum = {traj_reg[ACC_WIDTH-1], traj_reg}
                    + {{(ACC_WIDTH+1-DATA_W){motion[DATA_W-1]}}, motion};

    always_comb begin
        if (traj_sum[ACC_WIDTH] != traj_sum[ACC_WIDTH-1]) begin
            traj_clamped = traj_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                               : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            traj_clamped = traj_sum[ACC_WIDTH-1:0];
        end
    end

    assign diff     = {traj_reg[ACC_WIDTH-1], traj_reg} - {est_reg[ACC_WIDTH-1], est_reg};
    assign neg_diff = -diff;
    assign mag_ext  = 64'(mag_reg);

    assign step_full = 64'({prod_hi_reg, 4'b0000}) + 64'(prod_lo_reg >> FRAC_BITS);
    assign step      = step_full[ACC_WIDTH-1:0];
    assign est_upd   = up_reg ? est_reg + step : est_reg - step;

    assign out_sum = {{(ACC_WIDTH+2-DATA_W){motion_reg[DATA_W-1]}}, motion_reg}
                   + {{2{est_reg[ACC_WIDTH-1]}}, est_reg}
                   - {{2{traj_reg[ACC_WIDTH-1]}}, traj_reg};

    always_comb begin
        if (out_sum > OUT_MAX) begin
            fixed_val = 32'sh7FFF_FFFF;
        end else if (out_sum < OUT_MIN) begin
            fixed_val = 32'sh8000_0000;
        end else begin
            fixed_val = out_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            traj_reg <= '0;
            est_reg  <= '0;
        end else begin
            if (ctrl.load) begin
                traj_reg <= traj_clamped;
                if (ctrl.first) begin
                    est_reg <= '0;
                end
            end
            if (ctrl.upd) begin
                est_reg <= est_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            motion_reg <= motion;
        end
        if (ctrl.mag) begin
            up_reg  <= !diff[ACC_WIDTH];
            mag_reg <= diff[ACC_WIDTH] ? neg_diff[ACC_WIDTH-1:0] : diff[ACC_WIDTH-1:0];
        end
        if (ctrl.mul) begin
            prod_lo_reg <= mag_ext[31:0] * gain;
            prod_hi_reg <= mag_ext[63:32] * gain;
        end
    end

endmodule

// ===== rtl/kalman_trajectory_smoother_core.sv =====
// Top level of the Kalman trajectory smoother: sequencer, configuration registers,
// three axis lanes, the shared gain unit and the result register. Depends on kts_pkg,
// kts_lane and kts_gain.
`timescale 1ns / 1ps

// The input channel (s_) takes one item per video frame: motion_x, motion_y and
// motion_angle in signed Q16.16. The result channel (m_) returns one item per input
// with the corrected fixed_x, fixed_y and fixed_angle, saturated to Q16.16.
// The configuration channel writes process noise (index 0) and measurement noise
// (index 1), both unsigned Q4.28; other indexes are ignored. It is always ready.
// The first item after reset clears the estimate and sets the covariance to one; it
// skips the gain and lane steps and goes straight to the output state. Every later
// item runs the shared gain divider, which produces one quotient bit per cycle,
// followed by the magnitude, multiply and update steps in the lanes. One item is
// processed at a time; the input becomes ready at the same edge that registers the
// result. The result register holds an item until the receiver takes it; a new input
// item may be accepted while it waits, but a finished item waits in the sequencer
// until the result register is free. Reset clears the trajectory, the estimate and
// the result valid flag, sets the covariance to one and restores the register defaults.

module kalman_trajectory_smoother_core #(
    parameter int ACC_WIDTH = kts_pkg::ACC_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // motion_x [31:0], motion_y [63:32], motion_angle [95:64]
    input  logic [kts_pkg::NUM_AXES*kts_pkg::DATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // fixed_x [31:0], fixed_y [63:32], fixed_angle [95:64]
    output logic [kts_pkg::NUM_AXES*kts_pkg::DATA_W-1:0] m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kts_pkg::DATA_W-1:0]          cfg_data
);
    import kts_pkg::*;

    kts_state_t                      state_reg, state_next;
    logic                            first_frame_reg, first_frame_next;
    logic [DATA_W-1:0]               process_noise_reg;
    logic [DATA_W-1:0]               measure_noise_reg;
    logic                            m_tvalid_reg;
    logic [NUM_AXES*DATA_W-1:0]      m_tdata_reg;

    logic                            s_fire;
    logic                            out_load;
    kts_lane_ctrl_t                  lane_ctrl;
    kts_gain_ctrl_t                  gain_ctrl;
    logic [GAIN_W-1:0]               gain;
    logic                            gain_done;
    logic signed [DATA_W-1:0]        lane_fixed [NUM_AXES];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign lane_ctrl.load  = s_fire;
    assign lane_ctrl.first = first_frame_reg;
    assign lane_ctrl.mag   = (state_reg == ST_MAG);
    assign lane_ctrl.mul   = (state_reg == ST_MUL);
    assign lane_ctrl.upd   = (state_reg == ST_UPD);

    assign gain_ctrl.start = s_fire && !first_frame_reg;
    assign gain_ctrl.init  = s_fire && first_frame_reg;

    always_comb begin
        state_next       = state_reg;
        first_frame_next = first_frame_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    first_frame_next = 1'b0;
                    state_next = first_frame_reg ? ST_OUT : ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (gain_done) begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            first_frame_reg   <= 1'b1;
            process_noise_reg <= PROCESS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            first_frame_reg <= first_frame_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PROCESS_NOISE: process_noise_reg <= cfg_data;
                    REG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                m_tdata_reg[i*DATA_W +: DATA_W] <= lane_fixed[i];
            end
        end
    end

    kts_gain u_gain (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (gain_ctrl),
        .process_noise (process_noise_reg),
        .measure_noise (measure_noise_reg),
        .gain          (gain),
        .done          (gain_done)
    );

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        kts_lane #(
            .ACC_WIDTH (ACC_WIDTH)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .motion    (s_tdata[g*DATA_W +: DATA_W]),
            .gain      (gain),
            .fixed_val (lane_fixed[g])
        );
    end

endmodule

// ===== rtl/kts_checker.sv =====
// Port-level checks for the Kalman trajectory smoother core, bound to the top level.
// Depends on kts_pkg and kalman_trajectory_smoother_core.
`timescale 1ns / 1ps

module kts_checker (
    input logic                                        aclk,
    input logic                                        aresetn,
    input logic                                        s_tvalid,
    input logic                                        s_tready,
    input logic                                        m_tvalid,
    input logic                                        m_tready,
    input logic [kts_pkg::NUM_AXES*kts_pkg::DATA_W-1:0] m_tdata
);

    // No result is pending right after reset.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Items are processed one at a time, so the input closes after an accept.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // A result never appears in the cycle right after its item is accepted.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind kalman_trajectory_smoother_core kts_checker u_kts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
